[src/rpd_pkg.sv]
`default_nettype none

package rpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 12;
  localparam int unsigned StatusW = 2;

  // Largest value the decoded-length counter and limit register can hold.
  localparam int unsigned CountMax = (1 << CountW) - 1;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             final_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic [ByteW-1:0] repeat_count;
    logic             end_of_payload;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] decoded_limit;
  } cfg_item_t;

  // Decode outcome for one request: whether a result is produced, and its payload.
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } dec_res_t;

endpackage

`default_nettype wire

[src/rpd_stream_if.sv]
`default_nettype none

interface rpd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/rpd_in_stage.sv]
`default_nettype none

module rpd_in_stage
  import rpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  input  logic     advance_i,
  output logic     in_ready_o,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // Take a new request whenever the held one is empty or leaves this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[src/rpd_decode.sv]
`default_nettype none

module rpd_decode
  import rpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  in_item_t          item_i,
  input  logic [CountW-1:0] limit_i,
  output dec_res_t          res_o
);

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  lit_q, lit_d;
  logic [ByteW-1:0]  pend_q, pend_d;
  logic [CountW-1:0] count_q, count_d;
  status_e           err_q, err_d;

  logic [ByteW-1:0]  lit_dec;
  logic [CountW:0]   sum_rep;
  logic [CountW:0]   sum_lit;
  logic [CountW:0]   sum_one;
  logic              fin;
  logic [ByteW-1:0]  b;

  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    pend_d  = pend_q;
    count_d = count_q;
    err_d   = err_q;
    res_o   = '0;

    fin     = item_i.final_byte;
    b       = item_i.code_byte;
    lit_dec = lit_q - ByteW'(1);
    sum_rep = {1'b0, count_q} + (CountW+1)'(pend_q);
    sum_lit = {1'b0, count_q} + (CountW+1)'(b[ByteW-2:0]) + (CountW+1)'(1);
    sum_one = {1'b0, count_q} + (CountW+1)'(1);

    if (err_q == ST_OK) begin
      priority if (phase_q == PH_LIT) begin
        lit_d = lit_dec;
        if (fin && (lit_dec != '0)) begin
          err_d = ST_TRUNC;
        end else begin
          count_d                    = sum_one[CountW-1:0];
          res_o.emit                 = 1'b1;
          res_o.item.byte_value      = b;
          res_o.item.repeat_count    = ByteW'(1);
          res_o.item.end_of_payload  = fin;
          if (lit_dec == '0) begin
            phase_d = PH_CTRL;
          end
        end
      end else if (phase_q == PH_REP) begin
        if (sum_rep > {1'b0, limit_i}) begin
          err_d = ST_OVER;
        end else begin
          count_d                    = sum_rep[CountW-1:0];
          res_o.emit                 = 1'b1;
          res_o.item.byte_value      = b;
          res_o.item.repeat_count    = pend_q;
          res_o.item.end_of_payload  = fin;
          phase_d                    = PH_CTRL;
          pend_d                     = '0;
        end
      end else begin
        // Control byte (an unused phase code decodes the same way).
        if (fin) begin
          err_d = ST_TRUNC;
        end else if (b[ByteW-1]) begin
          pend_d  = {1'b0, b[ByteW-2:0]} + ByteW'(2);
          phase_d = PH_REP;
        end else if (sum_lit > {1'b0, limit_i}) begin
          err_d = ST_OVER;
        end else begin
          lit_d   = {1'b0, b[ByteW-2:0]} + ByteW'(1);
          phase_d = PH_LIT;
        end
      end
    end

    if (fin) begin
      if (!res_o.emit) begin
        res_o.emit                = 1'b1;
        res_o.item.end_of_payload = 1'b1;
        res_o.item.status         = err_d;
      end
      phase_d = PH_CTRL;
      lit_d   = '0;
      pend_d  = '0;
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      lit_q   <= '0;
      pend_q  <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      pend_q  <= pend_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.final_byte |=> phase_q == PH_CTRL && count_q == '0 && err_q == ST_OK)
    else $error("payload state not cleared after final byte");

  a_silent_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && err_q != ST_OK && !item_i.final_byte |-> !res_o.emit)
    else $error("result produced while payload is in error");

endmodule

`default_nettype wire

[src/rpd_out_stage.sv]
`default_nettype none

module rpd_out_stage
  import rpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  input  logic      out_ready_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // Free when empty or when the held result is taken this cycle.
  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule

`default_nettype wire

[src/rle_packet_decompressor.sv]
`default_nettype none

// Run-length payload decoder in the PackBits style. Compressed bytes arrive one per request on
// in_i, the last byte of a payload flagged by final_byte. A control byte below 128 opens a literal
// run of (value + 1) bytes, each decoded into one result with repeat_count 1; a control byte of
// 128 or more makes the next byte a result with repeat_count (value - 126). Control bytes give no
// result of their own. The total decoded length is checked against decoded_limit (written on cfg_i,
// reset to MAX_DECODED_BYTES clamped to 4095); an overrun sets status 1, and a payload that ends
// inside a run or on a control byte sets status 2. Once in error the block emits nothing until the
// final byte, which then yields a status-only result (repeat_count 0) so the consumer drops the
// packet; every final byte yields exactly one result. Throughput is one byte per clock while
// neither side stalls: the decode and length check sit in one short path from the input register
// to the result register, from which the result is offered. Either side may stall freely. The
// configuration port is always ready and should be written only while the block is idle.

module rle_packet_decompressor
  import rpd_pkg::*;
#(
  parameter int unsigned MAX_DECODED_BYTES = 2048
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpd_stream_if.sink   in_i,
  rpd_stream_if.source out_o,
  rpd_stream_if.sink   cfg_i
);

  localparam int unsigned LimitRstInt =
      (MAX_DECODED_BYTES > CountMax) ? CountMax : MAX_DECODED_BYTES;
  localparam logic [CountW-1:0] LimitRst = CountW'(LimitRstInt);

  logic [CountW-1:0] limit_q;

  logic      item_valid;
  in_item_t  item;
  logic      out_free;
  logic      fire;
  dec_res_t  dec_res;
  out_item_t out_data;
  logic      out_valid;

  // Length limit register: take each write at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data.decoded_limit;
    end
  end

  // Input register: hold one request until the decode step consumes it.
  rpd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_data_i    (in_i.data),
    .advance_i    (fire),
    .in_ready_o   (in_i.ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Decode the held byte only when the result register can take whatever it produces.
  assign fire = item_valid && out_free;

  rpd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item),
    .limit_i (limit_q),
    .res_o   (dec_res)
  );

  // Result register: parts the decoder from the consumer so a stalled result does not block
  // the next request from entering.
  rpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && dec_res.emit),
    .item_i      (dec_res.item),
    .out_ready_i (out_o.ready),
    .out_free_o  (out_free),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  a_status_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.repeat_count == '0 |-> out_data.end_of_payload)
    else $error("status-only result without end of payload");

  a_status_ok_mid_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.end_of_payload |-> out_data.status == ST_OK)
    else $error("error status on a result inside the payload");

endmodule

`default_nettype wire

[verif/rpd_decode_checker.sv]
`default_nettype none

module rpd_decode_checker
  import rpd_pkg::*;
#(
  parameter int unsigned MAX_DECODED_BYTES = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_item_t cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } run_phase_e;

  localparam logic [CountW-1:0] LimitAtReset =
    CountW'((MAX_DECODED_BYTES > CountMax) ? CountMax : MAX_DECODED_BYTES);

  logic [CountW-1:0] decoded_limit;
  run_phase_e        run_phase;
  logic [ByteW-1:0]  literal_left;
  logic [ByteW-1:0]  repeat_len;
  logic [CountW-1:0] decoded_count;
  status_e           payload_error;

  out_item_t expected_results[$];
  int        fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();

  function automatic void clear_payload();
    run_phase     = PH_CONTROL;
    literal_left  = '0;
    repeat_len    = '0;
    decoded_count = '0;
    payload_error = ST_OK;
  endfunction

  // Advance the decoder by one compressed byte; emit says whether a result follows.
  function automatic void decode_byte(input in_item_t item, output logic emit,
                                      output out_item_t res);
    int run_len;
    emit = 1'b0;
    res  = '0;
    if (payload_error == ST_OK) begin
      case (run_phase)
        PH_LITERAL: begin
          literal_left = literal_left - 8'd1;
          if (item.final_byte && literal_left != 0) begin
            payload_error = ST_TRUNC;
          end else begin
            decoded_count      = decoded_count + 12'd1;
            res.byte_value     = item.code_byte;
            res.repeat_count   = 8'd1;
            res.end_of_payload = item.final_byte;
            res.status         = ST_OK;
            emit               = 1'b1;
            if (literal_left == 0) run_phase = PH_CONTROL;
          end
        end
        PH_REPEAT: begin
          if (int'(decoded_count) + int'(repeat_len) > int'(decoded_limit)) begin
            payload_error = ST_OVER;
          end else begin
            decoded_count      = decoded_count + CountW'(repeat_len);
            res.byte_value     = item.code_byte;
            res.repeat_count   = repeat_len;
            res.end_of_payload = item.final_byte;
            res.status         = ST_OK;
            emit               = 1'b1;
            run_phase          = PH_CONTROL;
            repeat_len         = '0;
          end
        end
        default: begin
          if (item.final_byte) begin
            payload_error = ST_TRUNC;
          end else if (item.code_byte[7]) begin
            repeat_len = {1'b0, item.code_byte[6:0]} + 8'd2;
            run_phase  = PH_REPEAT;
          end else begin
            run_len = int'(item.code_byte) + 1;
            if (int'(decoded_count) + run_len > int'(decoded_limit)) begin
              payload_error = ST_OVER;
            end else begin
              literal_left = ByteW'(run_len);
              run_phase    = PH_LITERAL;
            end
          end
        end
      endcase
    end
    if (item.final_byte) begin
      if (!emit) begin
        res.byte_value     = '0;
        res.repeat_count   = '0;
        res.end_of_payload = 1'b1;
        res.status         = payload_error;
        emit               = 1'b1;
      end
      clear_payload();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic      emit;
    out_item_t predicted;
    out_item_t want;
    if (!rst_ni) begin
      decoded_limit = LimitAtReset;
      clear_payload();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) decoded_limit = cfg_data_i.decoded_limit;
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_data_i, emit, predicted);
        if (emit) expected_results.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: value %0d count %0d end %0d status %0d",
                     out_data_i.byte_value, out_data_i.repeat_count,
                     out_data_i.end_of_payload, out_data_i.status);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.byte_value !== want.byte_value ||
              out_data_i.repeat_count !== want.repeat_count ||
              out_data_i.end_of_payload !== want.end_of_payload ||
              out_data_i.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected value %0d count %0d end %0d status %0d, got %0d %0d %0d %0d",
                       want.byte_value, want.repeat_count, want.end_of_payload, want.status,
                       out_data_i.byte_value, out_data_i.repeat_count,
                       out_data_i.end_of_payload, out_data_i.status);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[verif/rle_packet_decompressor_test.sv]
`default_nettype none

// Stimulus and verdict for the run-length payload decoder. The checker beside the block watches
// every request on the three channels, predicts each result and compares; this module only
// drives payloads, the limit register and the result-side stalls.
module rle_packet_decompressor_test;
  import rpd_pkg::*;

  localparam int unsigned MaxDecoded    = 2048;
  // Slowest run: ~1600 bytes, each with a sender gap and a long result stall, plus limit writes.
  localparam int unsigned CycleLimit    = 400000;
  localparam int          ItemsPerPhase = 150;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          fail_count;
  int          pending;

  rpd_stream_if #(.T(in_item_t))  in_if  ();
  rpd_stream_if #(.T(out_item_t)) out_if ();
  rpd_stream_if #(.T(cfg_item_t)) cfg_if ();

  rle_packet_decompressor #(
    .MAX_DECODED_BYTES(MaxDecoded)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  rpd_decode_checker #(
    .MAX_DECODED_BYTES(MaxDecoded)
  ) decode_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost result never lets the run drain.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result-side stalls: switch between always ready, coin flips, long stalls and a fixed
  // duty pattern, each held for a random stretch.
  initial begin : receiver
    int stall_mode;
    int mode_left;
    out_if.ready = 1'b0;
    stall_mode   = 0;
    mode_left    = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = int'($urandom_range(0, 3));
        mode_left  = int'($urandom_range(8, 60));
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          out_if.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          out_if.ready <= ((mode_left % 8) < 5);
        end
      endcase
    end
  end

  // Send one compressed byte as one request. Bursts of random length are separated by gaps
  // of random length; the valid stays high across back-to-back requests.
  task automatic send_byte(input logic [ByteW-1:0] code, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(50, 200))
                                               : int'($urandom_range(1, 16));
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= '{code_byte: code, final_byte: fin};
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  // Literal run: control byte len-1, then len data bytes, the last one optionally final.
  task automatic send_literal(input int len, input logic fin);
    send_byte(ByteW'(len - 1), 1'b0);
    for (int i = 0; i < len; i++)
      send_byte(ByteW'($urandom_range(0, 255)), fin && (i == len - 1));
  endtask

  task automatic send_repeat(input logic [ByteW-1:0] ctrl, input logic [ByteW-1:0] value,
                             input logic fin);
    send_byte(ctrl, 1'b0);
    send_byte(value, fin);
  endtask

  // A sequence of well-formed runs; close it with a final byte only when asked. Most are short,
  // a few are long enough to push the decoded length toward the limit.
  task automatic send_runs(input int runs, input logic close);
    logic last;
    int   len;
    for (int r = 0; r < runs; r++) begin
      last = close && (r == runs - 1);
      if ($urandom_range(0, 1) == 1) begin
        send_repeat(ByteW'($urandom_range(128, 255)), ByteW'($urandom_range(0, 255)), last);
      end else begin
        len = ($urandom_range(0, 15) == 0) ? int'($urandom_range(1, 128))
                                           : int'($urandom_range(1, 6));
        send_literal(len, last);
      end
    end
  endtask

  // Mostly well-formed payloads with random content, the rest truncated payloads and noise.
  // Every payload ends on a final byte so the block is idle between payloads.
  task automatic send_random_packet();
    int pick;
    int len;
    int cut;
    pick = int'($urandom_range(0, 99));
    if (pick < 72) begin
      send_runs(($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 30))
                                            : int'($urandom_range(1, 6)), 1'b1);
    end else if (pick < 88) begin
      send_runs(int'($urandom_range(0, 3)), 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        // end the payload on a control byte of either kind
        send_byte(ByteW'($urandom_range(0, 255)), 1'b1);
      end else begin
        // cut a literal run short
        len = int'($urandom_range(2, 12));
        cut = int'($urandom_range(1, len - 1));
        send_byte(ByteW'(len - 1), 1'b0);
        for (int i = 0; i < cut; i++)
          send_byte(ByteW'($urandom_range(0, 255)), i == cut - 1);
      end
    end else begin
      len = int'($urandom_range(1, 12));
      for (int i = 0; i < len; i++)
        send_byte(ByteW'($urandom_range(0, 255)),
                  (i == len - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  // Write the limit register only with the block idle: drop the input valid, wait for every
  // expected result, then wait on for the pipeline to empty.
  task automatic write_limit(input logic [CountW-1:0] lim);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{decoded_limit: lim};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CountW-1:0] phase_limits[8];
    int                target;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset limit.
    send_literal(1, 1'b1);                     // shortest literal, ends the payload
    send_repeat(8'hFF, 8'hFF, 1'b1);           // longest repeat
    send_repeat(8'h80, 8'h00, 1'b0);           // shortest repeat
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h05, 1'b1);                    // payload ends on a literal control byte
    send_byte(8'h80, 1'b1);                    // payload ends on a repeat control byte
    send_byte(8'h02, 1'b0);                    // literal run cut short by the final byte
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);

    // Zero limit: literal overrun on the control byte, bytes after the error stay silent.
    write_limit(12'd0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_repeat(8'h80, 8'h44, 1'b1);           // repeat overrun on the final value byte
    send_byte(8'h00, 1'b1);

    // Limit of one: a single literal byte fits exactly, a repeat of two does not.
    write_limit(12'd1);
    send_literal(1, 1'b1);
    send_repeat(8'h80, 8'h66, 1'b0);
    send_byte(8'h77, 1'b1);

    // Random part, one limit setting per phase.
    phase_limits = '{12'd2048, 12'd1, 12'd2047, CountW'($urandom_range(0, 2048)), 12'd0,
                     CountW'($urandom_range(16, 400)), CountW'($urandom_range(0, 2048)),
                     12'd2048};
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) send_random_packet();
    end

    // Drain: drop the valid, wait for the last result, then let the block settle before the verdict.
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
